### src/qtd_pkg.sv
`timescale 1ns / 1ps

package qtd_pkg;

  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 4;
  localparam int COORD_W = 10;
  localparam int SIDE_W  = 11;
  localparam int COLOR_W = 8;

  localparam logic [BYTE_W-1:0] TAG_LEAF  = 8'h4E;
  localparam logic [BYTE_W-1:0] TAG_SPLIT = 8'h42;
  localparam logic [CFG_W-1:0]  SIDE_LOG2_RESET = 4'd9;

  typedef enum logic [2:0] {
    ST_TAG,
    ST_RED,
    ST_GREEN,
    ST_BLUE,
    ST_CLIMB
  } qtd_state_t;

  typedef struct packed {
    logic restart;
    logic ld_red;
    logic ld_green;
    logic descend;
    logic cap_leaf;
    logic cap_bad;
    logic step;
  } qtd_cmd_t;

  typedef struct packed {
    logic is_leaf_tag;
    logic is_split_tag;
    logic can_split;
    logic level_zero;
    logic last_child;
  } qtd_status_t;

endpackage

### src/qtd_byte_if.sv
`timescale 1ns / 1ps

interface qtd_byte_if import qtd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

### src/qtd_fill_if.sv
`timescale 1ns / 1ps

interface qtd_fill_if import qtd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] region_x;
  logic [COORD_W-1:0] region_y;
  logic [SIDE_W-1:0]  region_side;
  logic [COLOR_W-1:0] fill_red;
  logic [COLOR_W-1:0] fill_green;
  logic [COLOR_W-1:0] fill_blue;
  logic               bad_tag;
  logic               image_done;

  modport source (output valid, output region_x, output region_y, output region_side,
                  output fill_red, output fill_green, output fill_blue,
                  output bad_tag, output image_done, input ready);
  modport sink   (input valid, input region_x, input region_y, input region_side,
                  input fill_red, input fill_green, input fill_blue,
                  input bad_tag, input image_done, output ready);
endinterface

### src/qtd_cfg_if.sv
`timescale 1ns / 1ps

interface qtd_cfg_if import qtd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] image_side_log2;

  modport source (output valid, output image_side_log2, input ready);
  modport sink   (input valid, input image_side_log2, output ready);
endinterface

### src/qtd_ctrl.sv
`timescale 1ns / 1ps

module qtd_ctrl import qtd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        cfg_valid,
  input  qtd_status_t status,
  output qtd_cmd_t    cmd
);

  qtd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_beat;
  logic       split_ok;
  logic       finish;

  assign in_ready  = (state_r != ST_CLIMB) && (!out_valid_r || out_ready);
  assign in_beat   = in_valid && in_ready;
  assign split_ok  = status.is_split_tag && status.can_split;
  assign finish    = (state_r == ST_CLIMB) && (status.level_zero || !status.last_child);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    if (cfg_valid) begin
      state_nxt = ST_TAG;
    end else begin
      case (state_r)
        ST_TAG: begin
          if (in_beat) begin
            if (status.is_leaf_tag) begin
              state_nxt = ST_RED;
            end else if (split_ok) begin
              state_nxt = ST_TAG;
            end else begin
              state_nxt = ST_CLIMB;
            end
          end
        end
        ST_RED: begin
          if (in_beat) state_nxt = ST_GREEN;
        end
        ST_GREEN: begin
          if (in_beat) state_nxt = ST_BLUE;
        end
        ST_BLUE: begin
          if (in_beat) state_nxt = ST_CLIMB;
        end
        ST_CLIMB: begin
          if (finish) state_nxt = ST_TAG;
        end
        default: state_nxt = ST_TAG;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.restart  = cfg_valid;
    cmd.ld_red   = (state_r == ST_RED) && in_beat;
    cmd.ld_green = (state_r == ST_GREEN) && in_beat;
    cmd.cap_leaf = (state_r == ST_BLUE) && in_beat;
    cmd.step     = (state_r == ST_CLIMB);
    if ((state_r == ST_TAG) && in_beat && !status.is_leaf_tag) begin
      cmd.descend = split_ok;
      cmd.cap_bad = !split_ok;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_TAG;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/qtd_datapath.sv
`timescale 1ns / 1ps

module qtd_datapath import qtd_pkg::*; #(
  parameter int MAX_SIDE_LOG2 = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qtd_cmd_t           cmd,
  output qtd_status_t        status,
  input  logic [BYTE_W-1:0]  stream_byte,
  input  logic [CFG_W-1:0]   cfg_side_log2,
  output logic [COORD_W-1:0] region_x,
  output logic [COORD_W-1:0] region_y,
  output logic [SIDE_W-1:0]  region_side,
  output logic [COLOR_W-1:0] fill_red,
  output logic [COLOR_W-1:0] fill_green,
  output logic [COLOR_W-1:0] fill_blue,
  output logic               bad_tag,
  output logic               image_done
);

  localparam int LVL_W  = $clog2(MAX_SIDE_LOG2 + 1);
  localparam int PATH_W = (MAX_SIDE_LOG2 > 1) ? $clog2(MAX_SIDE_LOG2) : 1;
  localparam int POS_W  = MAX_SIDE_LOG2;
  localparam int SPAN_W = MAX_SIDE_LOG2 + 1;

  logic [CFG_W-1:0]   side_log2_r;
  logic [LVL_W-1:0]   level_r;
  logic [1:0]         path_r [MAX_SIDE_LOG2];
  logic [POS_W-1:0]   x_r, y_r;
  logic [COLOR_W-1:0] red_r, green_r;

  logic [COORD_W-1:0] region_x_r, region_y_r;
  logic [SIDE_W-1:0]  region_side_r;
  logic [COLOR_W-1:0] fill_red_r, fill_green_r, fill_blue_r;
  logic               bad_tag_r, image_done_r;

  logic [LVL_W-1:0]   lg_eff;
  logic [LVL_W-1:0]   shift;
  logic [PATH_W-1:0]  path_idx;
  logic [1:0]         cur_child, next_child;
  logic [POS_W-1:0]   bit_mask;
  logic [SPAN_W-1:0]  side;
  logic [POS_W-1:0]   x_step_nxt, y_step_nxt;

  assign lg_eff     = (side_log2_r > CFG_W'(MAX_SIDE_LOG2)) ? LVL_W'(MAX_SIDE_LOG2)
                                                          : LVL_W'(side_log2_r);
  assign shift      = lg_eff - level_r;
  assign path_idx   = PATH_W'(level_r - 1'b1);
  assign cur_child  = path_r[path_idx];
  assign next_child = cur_child + 2'd1;
  assign bit_mask   = POS_W'(1) << shift;
  assign side       = SPAN_W'(1) << shift;

  assign status.is_leaf_tag  = (stream_byte == TAG_LEAF);
  assign status.is_split_tag = (stream_byte == TAG_SPLIT);
  assign status.can_split    = (level_r < lg_eff);
  assign status.level_zero   = (level_r == '0);
  assign status.last_child   = (cur_child == 2'd3);

  // climb clears this level's bit, sibling move writes the new child's bits
  always_comb begin
    if (status.last_child) begin
      x_step_nxt = x_r & ~bit_mask;
      y_step_nxt = y_r & ~bit_mask;
    end else begin
      x_step_nxt = (x_r & ~bit_mask) | (next_child[0] ? bit_mask : '0);
      y_step_nxt = (y_r & ~bit_mask) | (next_child[1] ? bit_mask : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_log2_r <= SIDE_LOG2_RESET;
      level_r     <= '0;
      x_r         <= '0;
      y_r         <= '0;
      for (int i = 0; i < MAX_SIDE_LOG2; i++) path_r[i] <= '0;
    end else if (cmd.restart) begin
      side_log2_r <= cfg_side_log2;
      level_r     <= '0;
      x_r         <= '0;
      y_r         <= '0;
      for (int i = 0; i < MAX_SIDE_LOG2; i++) path_r[i] <= '0;
    end else if (cmd.descend) begin
      level_r <= level_r + 1'b1;
    end else if (cmd.step && !status.level_zero) begin
      x_r <= x_step_nxt;
      y_r <= y_step_nxt;
      if (status.last_child) begin
        path_r[path_idx] <= '0;
        level_r          <= level_r - 1'b1;
      end else begin
        path_r[path_idx] <= next_child;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_red) red_r <= stream_byte;
    if (cmd.ld_green) green_r <= stream_byte;
    if (cmd.cap_leaf || cmd.cap_bad) begin
      region_x_r <= COORD_W'(x_r);
      region_y_r <= COORD_W'(y_r);
    end
    if (cmd.cap_leaf) begin
      region_side_r <= SIDE_W'(side);
      fill_red_r    <= red_r;
      fill_green_r  <= green_r;
      fill_blue_r   <= stream_byte;
      bad_tag_r     <= 1'b0;
    end
    if (cmd.cap_bad) begin
      region_side_r <= '0;
      fill_red_r    <= '0;
      fill_green_r  <= '0;
      fill_blue_r   <= '0;
      bad_tag_r     <= 1'b1;
    end
    if (cmd.step) image_done_r <= status.level_zero;
  end

  assign region_x    = region_x_r;
  assign region_y    = region_y_r;
  assign region_side = region_side_r;
  assign fill_red    = fill_red_r;
  assign fill_green  = fill_green_r;
  assign fill_blue   = fill_blue_r;
  assign bad_tag     = bad_tag_r;
  assign image_done  = image_done_r;

endmodule

### src/quadtree_image_stream_decoder.sv
`timescale 1ns / 1ps
// channel  dir  payload
// in_if    in   stream_byte, one tag or color byte per beat
// out_if   out  region_x, region_y, region_side, fill rgb, bad_tag, image_done
// cfg_if   in   image_side_log2, restarts the tree at the root
//
// each tag, split or color byte is taken on a single beat
// a fill or error result is captured on the blue or tag beat and is offered once the climb
// state has stepped up the tree to the next sibling or to the root
// reset puts the tree at the root expecting a tag, with side log2 of 9
// a result waiting on out_ready holds, and a new byte is taken once it is taken

module quadtree_image_stream_decoder import qtd_pkg::*; #(
  parameter int MAX_SIDE_LOG2 = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  qtd_byte_if.sink    in_if,
  qtd_fill_if.source  out_if,
  qtd_cfg_if.sink     cfg_if
);

  qtd_cmd_t    cmd;
  qtd_status_t status;

  assign cfg_if.ready = 1'b1;

  qtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cfg_valid (cfg_if.valid),
    .status    (status),
    .cmd       (cmd)
  );

  qtd_datapath #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .stream_byte   (in_if.stream_byte),
    .cfg_side_log2 (cfg_if.image_side_log2),
    .region_x      (out_if.region_x),
    .region_y      (out_if.region_y),
    .region_side   (out_if.region_side),
    .fill_red      (out_if.fill_red),
    .fill_green    (out_if.fill_green),
    .fill_blue     (out_if.fill_blue),
    .bad_tag       (out_if.bad_tag),
    .image_done    (out_if.image_done)
  );

endmodule

### tb/sv/quadtree_image_stream_decoder_tb.sv
`timescale 1ns / 1ps

module quadtree_image_stream_decoder_tb;
  import qtd_pkg::*;

  localparam int MAX_LOG2      = 10;
  localparam int SETTLE_CYCLES = 2 * MAX_LOG2 + 8;
  localparam int PHASES        = 12;
  localparam int PHASE_BYTES   = 22;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIDE_W-1:0]  side;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               bad;
    logic               done;
  } fill_t;

  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [BYTE_W-1:0] data;
    bit                typed;
    fill_t             exp;
  } row_t;

  logic clk;
  logic rst_n;

  qtd_byte_if in_if ();
  qtd_fill_if out_if ();
  qtd_cfg_if  cfg_if ();

  quadtree_image_stream_decoder #(
    .MAX_SIDE_LOG2(MAX_LOG2)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  // decoder shadow state
  logic [CFG_W-1:0]   side_log2  = SIDE_LOG2_RESET;
  qtd_state_t         byte_phase = ST_TAG;
  logic [COLOR_W-1:0] held_red   = '0;
  logic [COLOR_W-1:0] held_green = '0;
  int                 tree_depth = 0;
  int                 child_idx [MAX_LOG2+1];

  fill_t pending_fills [$];
  row_t  script [$];

  logic [CFG_W-1:0] cfg_plan [PHASES] = '{0, 10, 1, 2, 15, 3, 5, 9, 7, 4, 8, 6};

  int errors      = 0;
  int bytes_sent  = 0;
  int fills_seen  = 0;
  int images_done = 0;
  int bad_seen    = 0;
  int cfg_writes  = 0;
  bit calm        = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic string fill_str(input fill_t f);
    return $sformatf("x=%0d y=%0d side=%0d rgb=%02h%02h%02h bad=%0b done=%0b",
                     f.x, f.y, f.side, f.red, f.green, f.blue, f.bad, f.done);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic int eff_log2();
    return (side_log2 > MAX_LOG2) ? MAX_LOG2 : int'(side_log2);
  endfunction

  function automatic void restart_tree();
    byte_phase = ST_TAG;
    tree_depth = 0;
    foreach (child_idx[i]) child_idx[i] = 0;
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    fill_t f;
    bit    emit;
    bit    bad;
    bit    finished;
    int    lg;
    int    px;
    int    py;
    f    = '0;
    emit = 1'b0;
    bad  = 1'b0;
    lg   = eff_log2();
    px   = 0;
    py   = 0;
    case (byte_phase)
      ST_RED: begin
        held_red   = b;
        byte_phase = ST_GREEN;
      end
      ST_GREEN: begin
        held_green = b;
        byte_phase = ST_BLUE;
      end
      ST_BLUE: begin
        emit       = 1'b1;
        byte_phase = ST_TAG;
        f.red      = held_red;
        f.green    = held_green;
        f.blue     = b;
      end
      default: begin
        if (b == TAG_LEAF) begin
          byte_phase = ST_RED;
        end else if (b == TAG_SPLIT && tree_depth < lg) begin
          child_idx[tree_depth] = 0;
          tree_depth++;
        end else begin
          emit = 1'b1;
          bad  = 1'b1;
        end
      end
    endcase
    if (emit) begin
      for (int i = 0; i < tree_depth && i < lg; i++) begin
        if (child_idx[i][0]) px += 1 << (lg - i - 1);
        if (child_idx[i][1]) py += 1 << (lg - i - 1);
      end
      f.x   = COORD_W'(px);
      f.y   = COORD_W'(py);
      f.bad = bad;
      if (!bad) f.side = SIDE_W'((tree_depth <= lg) ? (1 << (lg - tree_depth)) : 1);
      // climb to the next sibling, the root finishing the image
      finished = 1'b0;
      while (!finished) begin
        if (tree_depth == 0) begin
          restart_tree();
          f.done   = 1'b1;
          finished = 1'b1;
        end else if (child_idx[tree_depth-1] < 3) begin
          child_idx[tree_depth-1]++;
          finished = 1'b1;
        end else begin
          child_idx[tree_depth-1] = 0;
          tree_depth--;
        end
      end
      pending_fills.push_back(f);
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(input bit dive);
    int r;
    int split_pct;
    if (byte_phase != ST_TAG) begin
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return BYTE_W'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < 6) return BYTE_W'($urandom_range(0, 255));
    // dive: split every first child down to the bottom
    if (dive) begin
      return (tree_depth == 0 || child_idx[tree_depth-1] == 0) ? TAG_SPLIT : TAG_LEAF;
    end
    split_pct = (tree_depth < 2) ? 45 : ((tree_depth < eff_log2()) ? 20 : 8);
    return ($urandom_range(0, 99) < split_pct) ? TAG_SPLIT : TAG_LEAF;
  endfunction

  function automatic fill_t mk_fill(input int x, input int y, input int side,
                                    input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] bl, input bit bad, input bit done);
    fill_t f;
    f.x     = COORD_W'(x);
    f.y     = COORD_W'(y);
    f.side  = SIDE_W'(side);
    f.red   = r;
    f.green = g;
    f.blue  = bl;
    f.bad   = bad;
    f.done  = done;
    return f;
  endfunction

  function automatic void put_byte(input logic [BYTE_W-1:0] b);
    script.push_back('{ROW_BYTE, b, 1'b0, '0});
  endfunction

  function automatic void put_fill(input logic [BYTE_W-1:0] b, input fill_t f);
    script.push_back('{ROW_BYTE, b, 1'b1, f});
  endfunction

  function automatic void put_cfg(input logic [CFG_W-1:0] v);
    script.push_back('{ROW_CFG, BYTE_W'(v), 1'b0, '0});
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
    decode_byte(b);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_fills.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] v);
    cfg_if.valid           <= 1'b1;
    cfg_if.image_side_log2 <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    side_log2 = v;
    restart_tree();
    cfg_writes++;
  endtask

  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm || hold == 0) begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold = gap_len();
      end else begin
        out_if.ready <= 1'b0;
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    fill_t got;
    fill_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.x     = out_if.region_x;
      got.y     = out_if.region_y;
      got.side  = out_if.region_side;
      got.red   = out_if.fill_red;
      got.green = out_if.fill_green;
      got.blue  = out_if.fill_blue;
      got.bad   = out_if.bad_tag;
      got.done  = out_if.image_done;
      fills_seen++;
      if (got.bad === 1'b1) bad_seen++;
      if (got.done === 1'b1) images_done++;
      if (pending_fills.size() == 0) begin
        report_mismatch({"unexpected fill beat ", fill_str(got)});
      end else begin
        want = pending_fills.pop_front();
        if (got !== want) begin
          report_mismatch({"got ", fill_str(got), " want ", fill_str(want)});
        end
      end
    end
  end

  initial begin
    int  n;
    bit  dive;
    rst_n                  <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.stream_byte      <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.image_side_log2 <= '0;

    // reset side of 512
    put_byte(TAG_LEAF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_fill(8'h80, mk_fill(0, 0, 512, 8'h00, 8'hFF, 8'h80, 1'b0, 1'b1));
    put_fill(8'h00, mk_fill(0, 0, 0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    put_byte(TAG_SPLIT);
    put_byte(TAG_LEAF);
    put_byte(8'h01);
    put_byte(8'h02);
    put_fill(8'h03, mk_fill(0, 0, 256, 8'h01, 8'h02, 8'h03, 1'b0, 1'b0));
    put_fill(8'h4F, mk_fill(256, 0, 0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    put_byte(TAG_LEAF);
    put_byte(8'hAA);
    put_byte(8'h55);
    put_fill(8'hFE, mk_fill(0, 256, 256, 8'hAA, 8'h55, 8'hFE, 1'b0, 1'b0));
    put_fill(8'h43, mk_fill(256, 256, 0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    // one pixel image: split is refused
    put_cfg(4'd0);
    put_fill(TAG_SPLIT, mk_fill(0, 0, 0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    put_byte(TAG_LEAF);
    put_byte(8'h12);
    put_byte(8'h34);
    put_fill(8'h56, mk_fill(0, 0, 1, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1));
    // oversized side clamps to 1024
    put_cfg(4'd15);
    put_byte(TAG_LEAF);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_fill(8'hFF, mk_fill(0, 0, 1024, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1));
    // split past the deepest level, left mid tree
    put_cfg(4'd1);
    put_byte(TAG_SPLIT);
    put_byte(TAG_SPLIT);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_idle();
        write_cfg(script[i].data[CFG_W-1:0]);
      end else begin
        send_byte(script[i].data);
        if (script[i].typed && pending_fills.size() > 0) begin
          pending_fills[pending_fills.size()-1] = script[i].exp;
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_cfg(cfg_plan[ph]);
      dive = (ph % 3 == 1);
      calm = (ph % 4 == 3);
      n    = 0;
      while (n < PHASE_BYTES ||
             (n < 2 * PHASE_BYTES && !(byte_phase == ST_TAG && tree_depth == 0))) begin
        send_byte(pick_byte(dive));
        n++;
      end
    end

    in_if.valid <= 1'b0;
    calm = 1'b0;
    for (int k = 0; k < 4000 && pending_fills.size() > 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_fills.size() != 0) begin
      report_mismatch($sformatf("%0d fills never arrived", pending_fills.size()));
    end

    $display("tb: %0d stream bytes over %0d side settings, %0d fills checked",
             bytes_sent, cfg_writes, fills_seen);
    $display("tb: %0d bad tag fills, %0d images completed, %0d mismatches",
             bad_seen, images_done, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
